### design/postnet_barcode_codec_unit_macros.svh
`ifndef POSTNET_BARCODE_CODEC_UNIT_MACROS_SVH
`define POSTNET_BARCODE_CODEC_UNIT_MACROS_SVH

// Assertion helpers for the POSTNET codec. Each one samples on the rising
// edge of clock and is quiet while reset is high.

// The consequent must hold in the same cycle as the antecedent.
`define PBC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("postnet codec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("postnet codec: next-cycle check failed");

`endif

### design/pbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

   localparam int unsigned BarCount   = 27;
   localparam int unsigned DigitCount = 5;
   localparam int unsigned NumWidth   = 17;

   localparam logic [NumWidth-1:0] MaxNumber = 17'd99999;

   // Request beat.
   typedef struct packed {
      logic                func;
      logic [NumWidth-1:0] number_in;
      logic [BarCount-1:0] bars_in;
   } pbc_req_type;

   // Response beat.
   typedef struct packed {
      logic                valid_res;
      logic [NumWidth-1:0] number_out;
      logic [BarCount-1:0] bars_out;
   } pbc_rsp_type;

   // Result of the decode pipeline.
   typedef struct packed {
      logic                ok;
      logic [NumWidth-1:0] number;
   } pbc_dec_type;

   // Number of full bars in one group of five.
   function automatic logic [2:0] ones5(input logic [4:0] g);
      return {2'b00, g[0]} + {2'b00, g[1]} + {2'b00, g[2]} + {2'b00, g[3]} + {2'b00, g[4]};
   endfunction

   // Digit carried by a group: weights 7,4,2,1,0, and eleven means zero.
   function automatic logic [3:0] group_digit(input logic [4:0] g);
      logic [3:0] w;
      w = (g[4] ? 4'd7 : 4'd0) + (g[3] ? 4'd4 : 4'd0) + (g[2] ? 4'd2 : 4'd0)
        + {3'b000, g[1]};
      if (w == 4'd11) begin
         w = 4'd0;
      end
      return w;
   endfunction

   // Two-of-five pattern of a digit, leftmost bar in bit 4.
   function automatic logic [4:0] digit_bars(input logic [3:0] d);
      logic [4:0] p;
      case (d)
         4'd0:    p = 5'b11000;
         4'd1:    p = 5'b00011;
         4'd2:    p = 5'b00101;
         4'd3:    p = 5'b00110;
         4'd4:    p = 5'b01001;
         4'd5:    p = 5'b01010;
         4'd6:    p = 5'b01100;
         4'd7:    p = 5'b10001;
         4'd8:    p = 5'b10010;
         4'd9:    p = 5'b10100;
         default: p = 5'b00000;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### design/pbc_decode_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-stage bar decoder. It advances every cycle; the caller tracks which
// stages hold a live beat.
module pbc_decode_pipe
   import pbc_pkg::*;
(
   input  logic                clock,
   input  logic [BarCount-1:0] bars,
   output pbc_dec_type         dec_out
);

   logic       s1_ok_in;
   logic [3:0] s1_digit_in [DigitCount];
   logic       s1_ok_ff;
   logic [3:0] s1_digit_ff [DigitCount];

   logic       s2_ok_ff;
   logic [6:0] s2_p01_ff;
   logic [6:0] s2_p23_ff;
   logic [3:0] s2_d4_ff;

   logic        s3_ok_ff;
   logic [13:0] s3_q_ff;
   logic [3:0]  s3_d4_ff;

   logic                s4_ok_ff;
   logic [NumWidth-1:0] s4_num_ff;

   always_comb begin
      logic [4:0] grp;
      s1_ok_in = bars[BarCount-1] & bars[0];
      for (int g = 0; g < DigitCount; g++) begin
         grp            = bars[21 - 5*g +: 5];
         s1_digit_in[g] = group_digit(grp);
         if (ones5(grp) != 3'd2) begin
            s1_ok_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff    <= s1_ok_in;
      s1_digit_ff <= s1_digit_in;

      s2_ok_ff  <= s1_ok_ff;
      s2_p01_ff <= 7'(s1_digit_ff[0]) * 7'd10 + 7'(s1_digit_ff[1]);
      s2_p23_ff <= 7'(s1_digit_ff[2]) * 7'd10 + 7'(s1_digit_ff[3]);
      s2_d4_ff  <= s1_digit_ff[4];

      s3_ok_ff <= s2_ok_ff;
      s3_q_ff  <= 14'(s2_p01_ff) * 14'd100 + 14'(s2_p23_ff);
      s3_d4_ff <= s2_d4_ff;

      s4_ok_ff  <= s3_ok_ff;
      s4_num_ff <= NumWidth'(s3_q_ff) * 17'd10 + NumWidth'(s3_d4_ff);
   end

   assign dec_out.ok     = s4_ok_ff;
   assign dec_out.number = s4_num_ff;

endmodule

`default_nettype wire

### design/postnet_barcode_codec_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Direction  Beat taken when
// request   start, busy, req_data        in         start high and busy low
// response  rsp_strobe, rsp_data         out        rsp_strobe high (one cycle)
//
// A request beat is taken in any cycle, one per cycle, and its response
// comes out through the five register stages: four in the digit pipeline
// and the response register. busy is held low, since every stage moves on in
// every cycle. Synchronous reset clears the stage valid bits and the response
// strobe; payload registers are not reset. The receiver cannot stall, so no
// beat is ever held back.
`include "postnet_barcode_codec_unit_macros.svh"

module postnet_barcode_codec_unit
   import pbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  pbc_req_type req_data,
   output logic        rsp_strobe,
   output pbc_rsp_type rsp_data
);

   // Encoding splits the number as hi = number / 1000 and lo = number % 1000.
   // The quotient uses a reciprocal multiply that is exact for every 17-bit
   // input. hi then yields the first two digits, and lo the last three.

   logic accept;

   logic [34:0] s1_prod;
   logic [7:0]  s1_hi_in;

   logic                s1_valid_ff;
   logic                s1_func_ff;
   logic [NumWidth-1:0] s1_num_ff;
   logic [BarCount-1:0] s1_bars_ff;
   logic                s1_range_ok_ff;
   logic [7:0]          s1_hi_ff;

   logic [NumWidth-1:0] s2_lo_full;
   logic [15:0]         s2_d0_prod;

   logic                s2_valid_ff;
   logic                s2_func_ff;
   logic [NumWidth-1:0] s2_num_ff;
   logic [BarCount-1:0] s2_bars_ff;
   logic                s2_range_ok_ff;
   logic [7:0]          s2_hi_ff;
   logic [9:0]          s2_lo_ff;
   logic [3:0]          s2_d0_ff;

   logic [7:0]  s3_d1_full;
   logic [15:0] s3_d2_prod;

   logic                s3_valid_ff;
   logic                s3_func_ff;
   logic [NumWidth-1:0] s3_num_ff;
   logic [BarCount-1:0] s3_bars_ff;
   logic                s3_range_ok_ff;
   logic [9:0]          s3_lo_ff;
   logic [3:0]          s3_d0_ff;
   logic [3:0]          s3_d1_ff;
   logic [3:0]          s3_d2_ff;

   logic [9:0] s4_r_full;

   logic                s4_valid_ff;
   logic                s4_func_ff;
   logic [NumWidth-1:0] s4_num_ff;
   logic [BarCount-1:0] s4_bars_ff;
   logic                s4_range_ok_ff;
   logic [3:0]          s4_d0_ff;
   logic [3:0]          s4_d1_ff;
   logic [3:0]          s4_d2_ff;
   logic [6:0]          s4_r_ff;

   pbc_dec_type dec;

   logic [14:0]         out_d3_prod;
   logic [3:0]          out_d3;
   logic [6:0]          out_d4_full;
   logic [BarCount-1:0] enc_bars;
   pbc_rsp_type         rsp_in;
   logic                rsp_strobe_ff;
   pbc_rsp_type         rsp_data_ff;

   logic rsp_zero;
   logic rsp_framed;
   logic s4_enc_legal;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // The decoder runs beside the encode stages and lines up with stage four.
   pbc_decode_pipe u_decode (
      .clock   (clock),
      .bars    (req_data.bars_in),
      .dec_out (dec)
   );

   // Stage one: range check and the divide by 1000.
   assign s1_prod  = 35'(req_data.number_in) * 35'd134218;
   assign s1_hi_in = s1_prod[34:27];

   // Stage two: remainder by 1000 and the tens digit of hi.
   assign s2_lo_full = s1_num_ff - NumWidth'(s1_hi_ff) * 17'd1000;
   assign s2_d0_prod = 16'(s1_hi_ff) * 16'd205;

   // Stage three: units digit of hi and the hundreds digit of lo.
   assign s3_d1_full = s2_hi_ff - 8'(s2_d0_ff) * 8'd10;
   assign s3_d2_prod = 16'(s2_lo_ff) * 16'd41;

   // Stage four: the last two digits, still packed as a value below 100.
   assign s4_r_full = s3_lo_ff - 10'(s3_d2_ff) * 10'd100;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff     <= req_data.func;
      s1_num_ff      <= req_data.number_in;
      s1_bars_ff     <= req_data.bars_in;
      s1_range_ok_ff <= (req_data.number_in <= MaxNumber);
      s1_hi_ff       <= s1_hi_in;

      s2_func_ff     <= s1_func_ff;
      s2_num_ff      <= s1_num_ff;
      s2_bars_ff     <= s1_bars_ff;
      s2_range_ok_ff <= s1_range_ok_ff;
      s2_hi_ff       <= s1_hi_ff;
      s2_lo_ff       <= s2_lo_full[9:0];
      s2_d0_ff       <= s2_d0_prod[14:11];

      s3_func_ff     <= s2_func_ff;
      s3_num_ff      <= s2_num_ff;
      s3_bars_ff     <= s2_bars_ff;
      s3_range_ok_ff <= s2_range_ok_ff;
      s3_lo_ff       <= s2_lo_ff;
      s3_d0_ff       <= s2_d0_ff;
      s3_d1_ff       <= s3_d1_full[3:0];
      s3_d2_ff       <= s3_d2_prod[15:12];

      s4_func_ff     <= s3_func_ff;
      s4_num_ff      <= s3_num_ff;
      s4_bars_ff     <= s3_bars_ff;
      s4_range_ok_ff <= s3_range_ok_ff;
      s4_d0_ff       <= s3_d0_ff;
      s4_d1_ff       <= s3_d1_ff;
      s4_d2_ff       <= s3_d2_ff;
      s4_r_ff        <= s4_r_full[6:0];

      rsp_data_ff    <= rsp_in;
   end

   // Output stage: split the last two digits, build the code with its two
   // frame bars, then pick the encode or decode result. An illegal beat
   // gives all-zero number and bars.
   assign out_d3_prod = 15'(s4_r_ff) * 15'd205;
   assign out_d3      = out_d3_prod[14:11];
   assign out_d4_full = s4_r_ff - 7'(out_d3) * 7'd10;

   assign enc_bars = {1'b1, digit_bars(s4_d0_ff), digit_bars(s4_d1_ff),
                      digit_bars(s4_d2_ff), digit_bars(out_d3),
                      digit_bars(out_d4_full[3:0]), 1'b1};

   always_comb begin
      rsp_in = '0;
      if (s4_func_ff) begin
         if (dec.ok) begin
            rsp_in.valid_res  = 1'b1;
            rsp_in.number_out = dec.number;
            rsp_in.bars_out   = s4_bars_ff;
         end
      end else begin
         if (s4_range_ok_ff) begin
            rsp_in.valid_res  = 1'b1;
            rsp_in.number_out = s4_num_ff;
            rsp_in.bars_out   = enc_bars;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Terms used by the checks below.
   assign rsp_zero     = (rsp_data.number_out == '0) && (rsp_data.bars_out == '0);
   assign rsp_framed   = rsp_data.bars_out[BarCount-1] && rsp_data.bars_out[0]
                         && (rsp_data.number_out <= MaxNumber);
   assign s4_enc_legal = s4_valid_ff && !s4_func_ff && s4_range_ok_ff;

   // An illegal beat must come out fully cleared.
   `PBC_ASSERT_IMP(a_invalid_cleared, rsp_strobe && !rsp_data.valid_res, rsp_zero)
   // A legal beat always carries both frame bars and an in-range number.
   `PBC_ASSERT_IMP(a_valid_framed, rsp_strobe && rsp_data.valid_res, rsp_framed)
   // An in-range encode leaving stage four must come out as legal.
   `PBC_ASSERT_NEXT(a_encode_legal, s4_enc_legal, rsp_strobe && rsp_data.valid_res)
   // A taken beat enters stage one.
   `PBC_ASSERT_NEXT(a_accept_enters, accept, s1_valid_ff)

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pbc_pkg::*;

   // Function select codes carried in the func field of a request beat.
   localparam logic FuncEncode = 1'b0;
   localparam logic FuncDecode = 1'b1;

   // The response follows its request through the pipeline registers, so a
   // short drain is plenty once nothing is outstanding.
   localparam int unsigned DrainCycles = 20;
   // The slowest legal run is about 1600 beats, each after the longest gap that
   // pick_gap draws, plus reset and the pipeline depth. The limit is several times that.
   localparam int unsigned CycleLimit = 500000;
   localparam int unsigned RandomBeats = 1550;

   // Holds the responses that the accepted requests call for, in order, and
   // checks each response beat against the oldest of them.
   class postnet_result_board;
      pbc_rsp_type awaited_results[$];
      int unsigned mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // Two-of-five group for one decimal digit, leftmost bar in bit 4.
      static function logic [4:0] group_for_digit(int unsigned d);
         logic [4:0] g;
         case (d)
            0: g = 5'b11000;
            1: g = 5'b00011;
            2: g = 5'b00101;
            3: g = 5'b00110;
            4: g = 5'b01001;
            5: g = 5'b01010;
            6: g = 5'b01100;
            7: g = 5'b10001;
            8: g = 5'b10010;
            default: g = 5'b10100;
         endcase
         return g;
      endfunction

      // Full 27-bar code of a number below 100000: frame bar, five digit
      // groups with the most significant digit first, frame bar.
      static function logic [BarCount-1:0] bars_for(int unsigned value);
         logic [BarCount-1:0] b;
         int unsigned scale;
         b = '0;
         b[BarCount-1] = 1'b1;
         b[0] = 1'b1;
         scale = 10000;
         for (int i = 0; i < DigitCount; i++) begin
            b[21 - 5 * i +: 5] = group_for_digit((value / scale) % 10);
            scale = scale / 10;
         end
         return b;
      endfunction

      // Expected response of one request beat.
      static function pbc_rsp_type postnet_convert(pbc_req_type r);
         pbc_rsp_type res;
         logic [4:0] grp;
         int unsigned weight;
         int unsigned value;
         bit legal;
         res = '0;
         if (r.func == FuncEncode) begin
            if (r.number_in <= MaxNumber) begin
               res.valid_res = 1'b1;
               res.number_out = r.number_in;
               res.bars_out = bars_for(r.number_in);
            end
         end else begin
            legal = r.bars_in[BarCount-1] && r.bars_in[0];
            value = 0;
            for (int i = 0; i < DigitCount; i++) begin
               grp = r.bars_in[21 - 5 * i +: 5];
               if ($countones(grp) != 2) begin
                  legal = 1'b0;
               end
               weight = 7 * grp[4] + 4 * grp[3] + 2 * grp[2] + grp[1];
               if (weight == 11) begin
                  weight = 0;
               end
               value = value * 10 + weight;
            end
            if (legal) begin
               res.valid_res = 1'b1;
               res.number_out = value[NumWidth-1:0];
               res.bars_out = r.bars_in;
            end
         end
         return res;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  want);
         mismatch_count++;
      endtask

      function void note_request(pbc_req_type r);
         awaited_results.push_back(postnet_convert(r));
      endfunction

      task check_result(pbc_rsp_type got);
         pbc_rsp_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected response beat", got.number_out, 0);
         end else begin
            want = awaited_results.pop_front();
            if (got.valid_res !== want.valid_res) begin
               report_mismatch("valid_res", got.valid_res, want.valid_res);
            end
            if (got.number_out !== want.number_out) begin
               report_mismatch("number_out", got.number_out, want.number_out);
            end
            if (got.bars_out !== want.bars_out) begin
               report_mismatch("bars_out", got.bars_out, want.bars_out);
            end
         end
      endtask

      function int unsigned outstanding();
         return awaited_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pbc_req_type req_data = '0;
   logic rsp_strobe;
   pbc_rsp_type rsp_data;

   postnet_result_board board = new();
   int unsigned cycle_count = 0;
   bit bursting = 1'b0;

   postnet_barcode_codec_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   // Every edge at which start is high and busy is low takes a request beat.
   // Both monitors read the values that stood before the edge, since all
   // testbench drives and the block's registers change by nonblocking update.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         board.note_request(req_data);
      end
   end

   // A response is present for exactly one cycle and cannot be held off, so
   // every strobed cycle is checked right away.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_result(rsp_data);
      end
   end

   // Watchdog: a hung pipeline or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("postnet_barcode_codec_unit regression: fail");
         $finish;
      end
   end

   function automatic pbc_req_type make_req(logic f, logic [NumWidth-1:0] n,
                                            logic [BarCount-1:0] b);
      pbc_req_type r;
      r.func = f;
      r.number_in = n;
      r.bars_in = b;
      return r;
   endfunction

   // Idle gap before a beat: mostly none or short, now and then long, and
   // none at all while a burst is running.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (bursting || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // A random request beat. Most decode beats are well-formed codes with a
   // random number inside, since only those reach the digit weighting; the
   // rest are codes with one bar flipped and plain noise. The field that the
   // chosen function ignores is always filled with noise.
   function automatic pbc_req_type random_request();
      pbc_req_type r;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      r.number_in = NumWidth'($urandom_range(0, 131071));
      r.bars_in = BarCount'($urandom_range(0, 27'h7FFFFFF));
      if (kind < 35) begin
         r.func = FuncEncode;
         r.number_in = NumWidth'($urandom_range(0, 99999));
      end else if (kind < 43) begin
         r.func = FuncEncode;
         r.number_in = NumWidth'($urandom_range(100000, 131071));
      end else if (kind < 80) begin
         r.func = FuncDecode;
         r.bars_in = postnet_result_board::bars_for($urandom_range(0, 99999));
      end else if (kind < 90) begin
         r.func = FuncDecode;
         r.bars_in = postnet_result_board::bars_for($urandom_range(0, 99999));
         r.bars_in[$urandom_range(0, BarCount - 1)] ^= 1'b1;
      end else begin
         r.func = FuncDecode;
      end
      return r;
   endfunction

   // Offers one beat after the given idle gap and returns at the edge that
   // takes it. start is only lowered when a gap follows, so a back-to-back
   // beat never sees start lowered and raised within one step.
   task automatic send_request(pbc_req_type r, int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      logic [BarCount-1:0] b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: range ends for encoding, out-of-range numbers, codes
      // holding every digit, broken frame bars, groups with too few or too
      // many bars, and the ignored field at its extremes.
      send_request(make_req(FuncEncode, 17'd0, 27'h7FFFFFF), pick_gap());
      send_request(make_req(FuncEncode, 17'd99999, 27'h0), pick_gap());
      send_request(make_req(FuncEncode, 17'd100000, 27'h0), pick_gap());
      send_request(make_req(FuncEncode, 17'h1FFFF, 27'h7FFFFFF), pick_gap());
      send_request(make_req(FuncEncode, 17'd12345, 27'h0), pick_gap());
      send_request(make_req(FuncEncode, 17'd67890, 27'h0), pick_gap());
      send_request(make_req(FuncDecode, 17'h1FFFF, postnet_result_board::bars_for(0)),
                   pick_gap());
      send_request(make_req(FuncDecode, 17'd0, postnet_result_board::bars_for(99999)),
                   pick_gap());
      send_request(make_req(FuncDecode, 17'd0, postnet_result_board::bars_for(13579)),
                   pick_gap());
      send_request(make_req(FuncDecode, 17'd0, postnet_result_board::bars_for(24680)),
                   pick_gap());

      // Leading frame bar missing, then trailing frame bar missing.
      b = postnet_result_board::bars_for(12345);
      b[BarCount-1] = 1'b0;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());
      b = postnet_result_board::bars_for(12345);
      b[0] = 1'b0;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());

      // First group with a single bar, middle group with three, last group
      // with none, and one group with all five.
      b = postnet_result_board::bars_for(12345);
      b[21 +: 5] = 5'b00001;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());
      b = postnet_result_board::bars_for(55555);
      b[11 +: 5] = 5'b00111;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());
      b = postnet_result_board::bars_for(77777);
      b[1 +: 5] = 5'b00000;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());
      b = postnet_result_board::bars_for(88888);
      b[6 +: 5] = 5'b11111;
      send_request(make_req(FuncDecode, 17'd0, b), pick_gap());

      send_request(make_req(FuncDecode, 17'd0, 27'h0), pick_gap());
      send_request(make_req(FuncDecode, 17'h1FFFF, 27'h7FFFFFF), pick_gap());

      // Random beats, with bursts of back-to-back beats switched on and off
      // in blocks so that the pipeline runs both full and sparse.
      for (int i = 0; i < RandomBeats; i++) begin
         if (i % 50 == 0) begin
            bursting = ($urandom_range(0, 3) == 0);
         end
         send_request(random_request(), pick_gap());
      end
      start <= 1'b0;

      while (board.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (board.mismatch_count == 0) begin
         $display("postnet_barcode_codec_unit regression: pass");
      end else begin
         $display("postnet_barcode_codec_unit regression: fail");
      end
      $finish;
   end

endmodule
